// ===== design/chdf_pkg.sv =====
// ----------------------------------------------------------------------------
// chdf_pkg: shared types of the cross-half duplicate finder
// Controller states and the command and status groups that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package chdf_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic clear_run;
      logic load;
      logic accept;
      logic scan_run;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic clear_done;
      logic scan_done;
   } status_type;

endpackage

// ===== design/chdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// chdf_ctrl: sequencing controller
// Steps the block through the table clearing pass, list loading, the scan
// up to the limit, the read drain and the single-cycle result report.
// ----------------------------------------------------------------------------
module chdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                csr_we,
   input  chdf_pkg::status_type status,
   output chdf_pkg::cmd_type    cmd,
   output logic                busy
);
   import chdf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (start && status.last_item) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // A register write abandons the list and wipes both tables again.
      if (csr_we) state_in = ST_CLEAR;
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_run = 1'b1;
         ST_LOAD: begin
            cmd.load   = 1'b1;
            cmd.accept = start;
         end
         ST_SCAN:   cmd.scan_run = 1'b1;
         ST_DRAIN:  cmd = '0;
         ST_REPORT: cmd.report = 1'b1;
         default:   cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_LOAD);

endmodule

// ===== design/chdf_datapath.sv =====
// ----------------------------------------------------------------------------
// chdf_datapath: position tables, counters and scan logic
// Holds the length register, the two last-position memories, the item
// counter, the shared sweep address and the captured result.
// ----------------------------------------------------------------------------
module chdf_datapath #(
   parameter int MAX_LENGTH  = 1024,
   parameter int VALUE_SPACE = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  chdf_pkg::cmd_type    cmd,
   output chdf_pkg::status_type status,
   input  logic                 csr_we,
   input  logic [10:0]          csr_wdata,
   input  logic [11:0]          req_value,
   output logic                 rsp_found,
   output logic [11:0]          rsp_common_value,
   output logic [9:0]           rsp_first_position,
   output logic [9:0]           rsp_second_position
);
   import chdf_pkg::*;

   localparam int ADDR_W = $clog2(VALUE_SPACE);
   localparam int POS_W  = $clog2(MAX_LENGTH);
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int TRI_W  = LEN_W + 2;
   localparam int WORD_W = POS_W + 1;

   // Configuration derived once at write time.
   logic [POS_W-1:0]  len_m1_ff, half_ff;
   logic [ADDR_W-1:0] limit_ff;
   logic [LEN_W-1:0]  len_eff;
   logic [TRI_W-1:0]  triple;
   logic [ADDR_W-1:0] limit_in;

   always_comb begin
      if (csr_wdata == 11'd0) begin
         len_eff = LEN_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_LENGTH)) begin
         len_eff = LEN_W'(MAX_LENGTH);
      end else begin
         len_eff = LEN_W'(csr_wdata);
      end
      triple = (TRI_W'(len_eff) << 1) + TRI_W'(len_eff);
      if (32'(triple) > 32'(VALUE_SPACE - 1)) begin
         limit_in = ADDR_W'(VALUE_SPACE - 1);
      end else begin
         limit_in = ADDR_W'(triple);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_m1_ff <= '0;
         half_ff   <= '0;
         limit_ff  <= ADDR_W'(3);
      end else if (csr_we) begin
         len_m1_ff <= POS_W'(len_eff - LEN_W'(1));
         half_ff   <= POS_W'(len_eff >> 1);
         limit_ff  <= limit_in;
      end
   end

   // Item counter and the sweep address shared by clearing and scanning.
   logic [POS_W-1:0]  item_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              last_item;

   assign last_item = (item_ff == len_m1_ff);

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         item_ff <= '0;
      end else if (cmd.accept) begin
         item_ff <= last_item ? '0 : item_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we || cmd.load) begin
         addr_ff <= '0;
      end else if (cmd.clear_run || cmd.scan_run) begin
         addr_ff <= addr_ff + ADDR_W'(1);
      end
   end

   assign status.last_item  = last_item;
   assign status.clear_done = (addr_ff == ADDR_W'(VALUE_SPACE - 1));
   assign status.scan_done  = (addr_ff == limit_ff);

   // Table write selection. Each word is a valid bit above the position.
   logic              in_range, to_first;
   logic [ADDR_W-1:0] val_addr;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              we_first, we_second;
   logic [ADDR_W-1:0] wa_first, wa_second;
   logic [WORD_W-1:0] wd_first, wd_second;

   assign in_range = (32'(req_value) <= 32'(limit_ff));
   assign to_first = (item_ff <= half_ff);
   assign val_addr = ADDR_W'(req_value);

   always_comb begin
      we_first  = 1'b0;
      we_second = 1'b0;
      wa_first  = addr_ff;
      wa_second = addr_ff;
      wd_first  = '0;
      wd_second = '0;
      if (cmd.clear_run) begin
         we_first  = 1'b1;
         we_second = 1'b1;
      end else if (rd_valid_ff) begin
         // Entries are wiped behind the scan so the next list starts empty.
         we_first  = 1'b1;
         we_second = 1'b1;
         wa_first  = rd_addr_ff;
         wa_second = rd_addr_ff;
      end else if (cmd.accept && in_range) begin
         we_first  = to_first;
         we_second = !to_first;
         wa_first  = val_addr;
         wa_second = val_addr;
         wd_first  = {1'b1, item_ff};
         wd_second = {1'b1, item_ff};
      end
   end

   logic [WORD_W-1:0] mem_first  [VALUE_SPACE];
   logic [WORD_W-1:0] mem_second [VALUE_SPACE];
   logic [WORD_W-1:0] rd_first_ff, rd_second_ff;

   always_ff @(posedge clock) begin
      if (we_first) mem_first[wa_first] <= wd_first;
      rd_first_ff <= mem_first[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (we_second) mem_second[wa_second] <= wd_second;
      rd_second_ff <= mem_second[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_run;
      end
      rd_addr_ff <= addr_ff;
   end

   // The first hit in scan order is the smallest common value.
   logic              hit;
   logic              res_found_ff;
   logic [ADDR_W-1:0] res_value_ff;
   logic [POS_W-1:0]  res_first_ff, res_second_ff;

   assign hit = rd_valid_ff && rd_first_ff[POS_W] && rd_second_ff[POS_W];

   always_ff @(posedge clock) begin
      if (reset || (cmd.accept && last_item)) begin
         res_found_ff  <= 1'b0;
         res_value_ff  <= '0;
         res_first_ff  <= '0;
         res_second_ff <= '0;
      end else if (hit && !res_found_ff) begin
         res_found_ff  <= 1'b1;
         res_value_ff  <= rd_addr_ff;
         res_first_ff  <= rd_first_ff[POS_W-1:0];
         res_second_ff <= rd_second_ff[POS_W-1:0];
      end
   end

   assign rsp_found           = res_found_ff;
   assign rsp_common_value    = 12'(res_value_ff);
   assign rsp_first_position  = 10'(res_first_ff);
   assign rsp_second_position = 10'(res_second_ff);

endmodule

// ===== design/cross_half_duplicate_finder.sv =====
// ----------------------------------------------------------------------------
// cross_half_duplicate_finder: smallest value common to both list halves
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// Values are transferred one per cycle while busy is low, from a list of L
// items. The last item starts a scan that reads both position memories one
// address per cycle from 0 to M = min(3*L, VALUE_SPACE-1). A drain state
// then passes on the last read, and the result is on rsp_valid for exactly
// one cycle; busy stays high through the scan, drain and report after the
// last transfer, and the receiver cannot stall it.
// After reset and after every csr_we write the block runs a clearing pass
// over all VALUE_SPACE table addresses, busy throughout. A write to the
// length register abandons any partly loaded list.
module cross_half_duplicate_finder #(
   parameter int MAX_LENGTH  = 1024,
   parameter int VALUE_SPACE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [11:0] rsp_common_value,
   output logic [9:0]  rsp_first_position,
   output logic [9:0]  rsp_second_position,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);
   import chdf_pkg::*;

   cmd_type    cmd;
   status_type status;

   chdf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .csr_we (csr_we),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   chdf_datapath #(
      .MAX_LENGTH  (MAX_LENGTH),
      .VALUE_SPACE (VALUE_SPACE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_value           (req_value),
      .rsp_found           (rsp_found),
      .rsp_common_value    (rsp_common_value),
      .rsp_first_position  (rsp_first_position),
      .rsp_second_position (rsp_second_position)
   );

   assign rsp_valid = cmd.report;

endmodule

// ===== design/chdf_checker.sv =====
// ----------------------------------------------------------------------------
// chdf_checker: port-level checks of the duplicate finder
// Watches the top level's ports and is attached to it by a bind.
// ----------------------------------------------------------------------------
module chdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_found,
   input logic [11:0] rsp_common_value,
   input logic [9:0]  rsp_first_position,
   input logic [9:0]  rsp_second_position,
   input logic        csr_we
);

   // A result is only reported while the block refuses new transfers.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result reported while block accepts transfers");

   // One list yields one result strobe, never two in a row.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // A miss reports all fields as zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_common_value == 12'd0 && rsp_first_position == 10'd0 &&
          rsp_second_position == 10'd0))
      else $error("not-found result carries non-zero fields");

   // Reset starts the clearing pass.
   assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // A register write starts the clearing pass.
   assert property (@(posedge clock) disable iff (reset) csr_we |=> busy)
      else $error("block not busy after a register write");

endmodule

bind cross_half_duplicate_finder chdf_checker u_chdf_checker (
   .clock               (clock),
   .reset               (reset),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_found           (rsp_found),
   .rsp_common_value    (rsp_common_value),
   .rsp_first_position  (rsp_first_position),
   .rsp_second_position (rsp_second_position),
   .csr_we              (csr_we)
);
